[rtl/dq_pkg.sv]
// Shared types and codes for the double-ended queue core.
`default_nettype none

package dq_pkg;

    // Width of one stored value.
    localparam int unsigned DATA_W = 32;

    // Request codes carried on s_tuser.
    typedef enum logic [2:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_LIST_FWD   = 3'd4,
        REQ_LIST_BWD   = 3'd5
    } req_e;

    // Status codes carried on m_tuser.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_EMPTY     = 2'd3
    } status_e;

    // The update that every cell of a chain makes.
    typedef enum logic [2:0] {
        CM_HOLD  = 3'd0,  // keep the value
        CM_SHR   = 3'd1,  // take the lower neighbor, cell zero takes the insert value
        CM_SHL   = 3'd2,  // take the upper neighbor
        CM_WRITE = 3'd3,  // the selected cell takes the insert value
        CM_ROT   = 3'd4   // take the upper neighbor, the selected cell takes the insert value
    } cell_mode_e;

    // Command broadcast along one chain.
    typedef struct packed {
        cell_mode_e              mode;
        logic [DATA_W-1:0]       ins;
    } chain_cmd_t;

    // Controller states.
    typedef enum logic [0:0] {
        CS_IDLE = 1'b0,
        CS_LIST = 1'b1
    } ctl_state_e;

endpackage

`default_nettype wire

[rtl/double_ended_queue_core.sv]
// Top level of the double-ended queue core: request decode, two cell chains, result register.
`default_nettype none

// Bounded double-ended queue of up to DEPTH signed 32-bit values. The contents are kept
// twice, in two chains of cells: one with the front entry in its first cell and one with
// the back entry in its first cell, so every pop reads a fixed cell and every push shifts
// one chain and writes one cell of the other. Push and pop requests may follow each other
// in consecutive cycles while the result register is free, each giving one result transfer.
// A list of n entries rotates the chain by one cell per cycle while the result register is
// free and sends out its first cell; after n steps the chain is back in its original order
// and no new request is taken meanwhile. An empty list gives one result. Request codes 6
// and 7 are taken and dropped without a result. The result register lets a new request in
// while a result is still waiting, as long as m_tready frees it in the same cycle.
module double_ended_queue_core
    import dq_pkg::*;
#(
    parameter int unsigned DEPTH = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Request channel.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] push_value
    input  wire logic [2:0]  s_tuser,   // [2:0] req_type
    // Result channel.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] data_value
    output logic [1:0]       m_tuser,   // [1:0] status
    output logic             m_tlast    // last_item
);

    localparam int unsigned IW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    // Control state.
    ctl_state_e        state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [IW-1:0]     list_idx_reg, list_idx_next;
    logic              list_bwd_reg, list_bwd_next;

    // Result register.
    logic              m_valid_reg;
    logic [DATA_W-1:0] m_data_reg;
    status_e           m_status_reg;
    logic              m_last_reg;

    logic              out_load;
    logic [DATA_W-1:0] out_data;
    status_e           out_status;
    logic              out_last;

    // Chain commands and heads.
    chain_cmd_t        f_cmd, b_cmd;
    logic [IW-1:0]     f_sel, b_sel;
    logic [DATA_W-1:0] f_head, b_head;

    logic              out_free;
    logic              s_fire;
    logic              is_full;
    logic              is_empty;
    logic [IW-1:0]     cnt_idx;
    logic [CW-1:0]     cnt_m1;
    logic [IW-1:0]     last_pos;
    logic              list_last;
    req_e              req;

    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == CS_IDLE) && out_free;
    assign s_fire    = s_tvalid && s_tready;
    assign is_full   = (count_reg == CW'(DEPTH));
    assign is_empty  = (count_reg == '0);
    assign cnt_idx   = count_reg[IW-1:0];
    assign cnt_m1    = count_reg - CW'(1);
    assign last_pos  = cnt_m1[IW-1:0];
    assign list_last = (list_idx_reg == last_pos);
    assign req       = req_e'(s_tuser);

    // Front chain: front entry in cell zero.
    dq_chain #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_front (
        .aclk (aclk),
        .cmd  (f_cmd),
        .sel  (f_sel),
        .head (f_head)
    );

    // Back chain: back entry in cell zero.
    dq_chain #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_back (
        .aclk (aclk),
        .cmd  (b_cmd),
        .sel  (b_sel),
        .head (b_head)
    );

    // Next state, chain commands and result selection.
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        list_idx_next = list_idx_reg;
        list_bwd_next = list_bwd_reg;
        f_cmd.mode    = CM_HOLD;
        f_cmd.ins     = s_tdata;
        b_cmd.mode    = CM_HOLD;
        b_cmd.ins     = s_tdata;
        f_sel         = cnt_idx;
        b_sel         = cnt_idx;
        out_load      = 1'b0;
        out_data      = '0;
        out_status    = ST_OK;
        out_last      = 1'b1;

        unique case (state_reg)
            CS_IDLE: begin
                if (s_fire) begin
                    unique case (req) inside
                        REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                            out_load = 1'b1;
                            if (is_full) begin
                                out_status = ST_OVERFLOW;
                            end else begin
                                count_next = count_reg + CW'(1);
                                if (req == REQ_PUSH_FRONT) begin
                                    f_cmd.mode = CM_SHR;
                                    b_cmd.mode = CM_WRITE;
                                end else begin
                                    b_cmd.mode = CM_SHR;
                                    f_cmd.mode = CM_WRITE;
                                end
                            end
                        end
                        REQ_POP_FRONT, REQ_POP_BACK: begin
                            out_load = 1'b1;
                            if (is_empty) begin
                                out_status = ST_UNDERFLOW;
                            end else begin
                                count_next = cnt_m1;
                                // The other chain loses its far entry through the count alone.
                                if (req == REQ_POP_FRONT) begin
                                    out_data   = f_head;
                                    f_cmd.mode = CM_SHL;
                                end else begin
                                    out_data   = b_head;
                                    b_cmd.mode = CM_SHL;
                                end
                            end
                        end
                        REQ_LIST_FWD, REQ_LIST_BWD: begin
                            if (is_empty) begin
                                out_load   = 1'b1;
                                out_status = ST_EMPTY;
                            end else begin
                                state_next    = CS_LIST;
                                list_idx_next = '0;
                                list_bwd_next = (req == REQ_LIST_BWD);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            CS_LIST: begin
                // Send cell zero and rotate it to the far end of the occupied span.
                if (out_free) begin
                    out_load      = 1'b1;
                    out_last      = list_last;
                    list_idx_next = list_idx_reg + IW'(1);
                    if (list_bwd_reg) begin
                        out_data   = b_head;
                        b_cmd.mode = CM_ROT;
                        b_cmd.ins  = b_head;
                        b_sel      = last_pos;
                    end else begin
                        out_data   = f_head;
                        f_cmd.mode = CM_ROT;
                        f_cmd.ins  = f_head;
                        f_sel      = last_pos;
                    end
                    if (list_last) begin
                        state_next = CS_IDLE;
                    end
                end
            end
            default: begin
                state_next = CS_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= CS_IDLE;
            count_reg    <= '0;
            list_idx_reg <= '0;
            list_bwd_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            list_idx_reg <= list_idx_next;
            list_bwd_reg <= list_bwd_next;
        end
    end

    // Result register: loaded when free, cleared when its transfer completes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg   <= out_data;
            m_status_reg <= out_status;
            m_last_reg   <= out_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

    // The entry count never passes the capacity.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("entry count above capacity");

    // A list walk only runs over a non-empty queue and stays inside it.
    a_list_span: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == CS_LIST) |-> (!is_empty && list_idx_reg <= last_pos))
        else $error("list index outside occupied span");

    // The queue contents do not change size during a list walk.
    a_list_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == CS_LIST) |=> $stable(count_reg))
        else $error("entry count changed during list");

    // Sending the final listed entry ends the walk.
    a_list_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == CS_LIST && out_free && list_last) |=> (state_reg == CS_IDLE))
        else $error("list walk did not end after final entry");

    // No request is taken while a list walk is running.
    a_list_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == CS_LIST) |-> !s_tready)
        else $error("request taken during list");

endmodule

`default_nettype wire

[rtl/dq_cell.sv]
// One storage cell of a shifting chain.
`default_nettype none

module dq_cell
    import dq_pkg::*;
#(
    parameter int unsigned IDX = 0,
    parameter int unsigned IW  = 6
) (
    input  wire logic              aclk,
    input  wire chain_cmd_t        cmd,
    input  wire logic [IW-1:0]     sel,
    input  wire logic [DATA_W-1:0] left_data,
    input  wire logic [DATA_W-1:0] right_data,
    output logic      [DATA_W-1:0] q
);

    localparam bit IS_FIRST = (IDX == 0);

    logic [DATA_W-1:0] q_reg;
    logic [DATA_W-1:0] q_next;
    logic              is_sel;

    assign is_sel = (sel == IW'(IDX));

    // Select the next value from the broadcast command.
    always_comb begin
        unique case (cmd.mode)
            CM_HOLD:  q_next = q_reg;
            CM_SHR:   q_next = IS_FIRST ? cmd.ins : left_data;
            CM_SHL:   q_next = right_data;
            CM_WRITE: q_next = is_sel ? cmd.ins : q_reg;
            CM_ROT:   q_next = is_sel ? cmd.ins : right_data;
            default:  q_next = q_reg;
        endcase
    end

    // Payload register, no reset needed.
    always_ff @(posedge aclk) begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

`default_nettype wire

[rtl/dq_chain.sv]
// A row of storage cells with its end entry at cell zero.
`default_nettype none

module dq_chain
    import dq_pkg::*;
#(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned IW    = 6
) (
    input  wire logic              aclk,
    input  wire chain_cmd_t        cmd,
    input  wire logic [IW-1:0]     sel,
    output logic      [DATA_W-1:0] head
);

    logic [DATA_W-1:0] cell_q [DEPTH];

    // Each cell sees its two neighbors; the end cells see themselves.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        localparam int unsigned LEFT  = (i == 0) ? 0 : i - 1;
        localparam int unsigned RIGHT = (i == DEPTH - 1) ? DEPTH - 1 : i + 1;

        dq_cell #(
            .IDX (i),
            .IW  (IW)
        ) u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .sel        (sel),
            .left_data  (cell_q[LEFT]),
            .right_data (cell_q[RIGHT]),
            .q          (cell_q[i])
        );
    end

    assign head = cell_q[0];

endmodule

`default_nettype wire
